### hw/rtl/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg: shared types and constants of the articulation point counter
// Vertex width, controller states, the stack frame layout and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package apc_pkg;

    localparam int VTX_W            = 7;
    localparam int DEF_MAX_VERTICES = 64;

    // Input command codes
    localparam logic CMD_EDGE   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef logic [VTX_W-1:0] t_vtx;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_EDGE_A = 10'b00_0000_0100,
        S_EDGE_B = 10'b00_0000_1000,
        S_OUTER  = 10'b00_0001_0000,
        S_LOAD   = 10'b00_0010_0000,
        S_SCAN   = 10'b00_0100_0000,
        S_CHECK  = 10'b00_1000_0000,
        S_POP    = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } t_state;

    // One saved level of the depth-first walk
    typedef struct packed {
        t_vtx vertex;
        t_vtx cursor;
        t_vtx low;
        t_vtx disc;
        t_vtx parent;
    } t_frame;

    typedef struct packed {
        logic clear_step;
        logic edge_load;
        logic edge_wa;
        logic edge_wb;
        logic find_start;
        logic outer_next;
        logic root_start;
        logic row_load;
        logic scan_step;
        logic scan_hit;
        logic tree_push;
        logic back_edge;
        logic pop_root_end;
        logic pop_issue;
        logic pop_apply;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic edge_ok;
        logic outer_over;
        logic outer_visited;
        logic u_over;
        logic row_hit;
        logic u_visited;
        logic sp_one;
    } t_dp_stat;

endpackage

`default_nettype wire

### hw/rtl/articulation_point_counter.sv
// ----------------------------------------------------------------------------
// articulation_point_counter: cut vertex count of an undirected graph
// Loads edges into an adjacency bit matrix, then on a finish transaction
// walks the graph depth first and returns the number of cut vertices.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------
//  input   | in        | i_valid / o_stall        | i_cmd, i_node_a, i_node_b
//  result  | out       | o_valid / i_stall        | o_cut_vertex_count
//  config  | in        | i_cfg_valid / o_cfg_ready| i_cfg_vertex_count
//
//  An edge transaction is accepted, then does a read-modify-write of row a
//  and of row b in the adjacency RAM (one write port).
//  A finish transaction walks the graph depth first from each unvisited
//  vertex in turn, scanning each adjacency row bit by bit.
//  After the result is taken a clearing sweep writes MAX_VERTICES rows (one
//  per cycle); the same sweep runs after reset. o_stall stays high throughout.
//  The result waits on o_valid while i_stall is high; config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module articulation_point_counter
    import apc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Input transactions
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_cmd,
    input  wire logic [VTX_W-1:0] i_node_a,
    input  wire logic [VTX_W-1:0] i_node_b,
    // Result transactions
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic      [VTX_W-1:0] o_cut_vertex_count,
    // Configuration write
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [VTX_W-1:0] i_cfg_vertex_count
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Hold ready high: the register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    apc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    apc_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_stat             (dp_stat),
        .i_cfg_we           (i_cfg_valid & o_cfg_ready),
        .i_cfg_vertex_count (i_cfg_vertex_count),
        .i_node_a           (i_node_a),
        .i_node_b           (i_node_b),
        .o_count            (o_cut_vertex_count)
    );

endmodule

`default_nettype wire

### hw/rtl/apc_ram.sv
// ----------------------------------------------------------------------------
// apc_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered (old data on collision).
// ----------------------------------------------------------------------------
`default_nettype none

module apc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/apc_datapath.sv
// ----------------------------------------------------------------------------
// apc_datapath: graph store, walk registers and stack of the counter
// Holds the adjacency rows, discovery numbers and the walk stack in RAMs,
// the top of the walk in registers, and carries out controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_datapath
    import apc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_stat        o_stat,
    input  wire logic       i_cfg_we,
    input  wire t_vtx       i_cfg_vertex_count,
    input  wire t_vtx       i_node_a,
    input  wire t_vtx       i_node_b,
    output t_vtx            o_count
);

    localparam int   ADDR_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam t_vtx MAX_V   = VTX_W'(MAX_VERTICES);
    localparam int   FRAME_W = $bits(t_frame);

    t_vtx                    r_vc, r_a, r_b, r_count, r_clock, r_outer, r_root, r_root_kids;
    t_vtx                    r_v, r_cur, r_low, r_disc, r_par, r_sp, r_found, r_child_low;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic [MAX_VERTICES-1:0] r_visited, r_cut, r_row;

    t_vtx                    n_eff;
    logic [ADDR_W-1:0]       a_ix, ra_ix, rb_ix, cur_ix, found_ix, outer_ix, sp_ix, sp2_ix;
    logic [ADDR_W-1:0]       pv_ix;

    logic                    adj_we;
    logic [ADDR_W-1:0]       adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
    logic                    disc_we;
    logic [ADDR_W-1:0]       disc_waddr;
    t_vtx                    disc_rdata;
    logic [FRAME_W-1:0]      stk_rdata;
    t_frame                  frame_rd, frame_wr;

    assign n_eff    = (r_vc > MAX_V) ? MAX_V : r_vc;
    assign a_ix     = ADDR_W'(i_node_a - 7'd1);
    assign ra_ix    = ADDR_W'(r_a - 7'd1);
    assign rb_ix    = ADDR_W'(r_b - 7'd1);
    assign cur_ix   = ADDR_W'(r_cur - 7'd1);
    assign found_ix = ADDR_W'(r_found - 7'd1);
    assign outer_ix = ADDR_W'(r_outer - 7'd1);
    assign sp_ix    = ADDR_W'(r_sp - 7'd1);
    assign sp2_ix   = ADDR_W'(r_sp - 7'd2);
    assign frame_rd = t_frame'(stk_rdata);
    assign pv_ix    = ADDR_W'(frame_rd.vertex - 7'd1);
    assign frame_wr = '{vertex: r_v, cursor: r_cur, low: r_low, disc: r_disc, parent: r_par};

    assign o_stat.clear_last    = (r_clr_addr == ADDR_W'(MAX_VERTICES - 1));
    assign o_stat.edge_ok       = (i_node_a != '0) && (i_node_a <= n_eff)
                               && (i_node_b != '0) && (i_node_b <= n_eff);
    assign o_stat.outer_over    = (r_outer > n_eff);
    assign o_stat.outer_visited = r_visited[outer_ix];
    assign o_stat.u_over        = (r_cur > n_eff);
    assign o_stat.row_hit       = r_row[cur_ix];
    assign o_stat.u_visited     = r_visited[found_ix];
    assign o_stat.sp_one        = (r_sp == 7'd1);
    assign o_count              = r_count;

    // Adjacency port selection
    always_comb begin
        adj_we    = 1'b0;
        adj_waddr = r_clr_addr;
        adj_wdata = '0;
        adj_raddr = cur_ix;
        if (i_cmd.clear_step) begin
            adj_we = 1'b1;
        end
        if (i_cmd.edge_load) begin
            adj_raddr = a_ix;
        end
        if (i_cmd.edge_wa) begin
            adj_we    = 1'b1;
            adj_waddr = ra_ix;
            adj_wdata = adj_rdata | (MAX_VERTICES'(1) << rb_ix);
            adj_raddr = rb_ix;
        end
        if (i_cmd.edge_wb) begin
            adj_we    = 1'b1;
            adj_waddr = rb_ix;
            adj_wdata = adj_rdata | (MAX_VERTICES'(1) << ra_ix);
        end
        if (i_cmd.root_start) begin
            adj_raddr = outer_ix;
        end
        if (i_cmd.tree_push) begin
            adj_raddr = found_ix;
        end
        if (i_cmd.pop_apply) begin
            adj_raddr = pv_ix;
        end
    end

    assign disc_we    = i_cmd.root_start | i_cmd.tree_push;
    assign disc_waddr = i_cmd.tree_push ? found_ix : outer_ix;

    apc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    apc_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_disc (
        .i_clk   (i_clk),
        .i_we    (disc_we),
        .i_waddr (disc_waddr),
        .i_wdata (r_clock),
        .i_raddr (cur_ix),
        .o_rdata (disc_rdata)
    );

    apc_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_VERTICES)) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tree_push),
        .i_waddr (sp_ix),
        .i_wdata (frame_wr),
        .i_raddr (sp2_ix),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc       <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_vc <= i_cfg_vertex_count;
            end
            if (i_cmd.clear_step) begin
                r_clr_addr <= o_stat.clear_last ? '0 : r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_load) begin
            r_a <= i_node_a;
            r_b <= i_node_b;
        end
        if (i_cmd.find_start) begin
            r_visited <= '0;
            r_cut     <= '0;
            r_count   <= '0;
            r_clock   <= 7'd1;
            r_outer   <= 7'd1;
        end
        if (i_cmd.outer_next) begin
            r_outer <= r_outer + 7'd1;
        end
        if (i_cmd.root_start) begin
            r_root              <= r_outer;
            r_root_kids         <= '0;
            r_v                 <= r_outer;
            r_cur               <= 7'd1;
            r_par               <= '0;
            r_disc              <= r_clock;
            r_low               <= r_clock;
            r_visited[outer_ix] <= 1'b1;
            r_clock             <= r_clock + 7'd1;
            r_sp                <= 7'd1;
        end
        if (i_cmd.row_load) begin
            r_row <= adj_rdata;
        end
        if (i_cmd.scan_step) begin
            r_cur <= r_cur + 7'd1;
        end
        if (i_cmd.scan_hit) begin
            r_found <= r_cur;
            r_cur   <= r_cur + 7'd1;
        end
        if (i_cmd.tree_push) begin
            if (r_v == r_root) begin
                r_root_kids <= r_root_kids + 7'd1;
            end
            r_v                 <= r_found;
            r_cur               <= 7'd1;
            r_par               <= r_v;
            r_disc              <= r_clock;
            r_low               <= r_clock;
            r_visited[found_ix] <= 1'b1;
            r_clock             <= r_clock + 7'd1;
            r_sp                <= r_sp + 7'd1;
        end
        // Back edge: pull the low number down, but not along the tree edge
        if (i_cmd.back_edge && (r_found != r_par) && (disc_rdata < r_low)) begin
            r_low <= disc_rdata;
        end
        // Root closes its tree: it cuts when it has two or more tree children
        if (i_cmd.pop_root_end) begin
            r_sp <= '0;
            if (r_root_kids > 7'd1) begin
                r_count <= r_count + 7'd1;
            end
        end
        if (i_cmd.pop_issue) begin
            r_sp        <= r_sp - 7'd1;
            r_child_low <= r_low;
        end
        if (i_cmd.pop_apply) begin
            // Root flag is settled at the end of its tree, skip it here
            if ((r_child_low >= frame_rd.disc) && (frame_rd.vertex != r_root)
                && !r_cut[pv_ix]) begin
                r_cut[pv_ix] <= 1'b1;
                r_count      <= r_count + 7'd1;
            end
            r_v    <= frame_rd.vertex;
            r_cur  <= frame_rd.cursor;
            r_disc <= frame_rd.disc;
            r_par  <= frame_rd.parent;
            r_low  <= (r_child_low < frame_rd.low) ? r_child_low : frame_rd.low;
        end
    end

    sp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tree_push |-> (r_sp < MAX_V))
        else $error("walk stack overflow");

    push_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tree_push |-> ((r_found != '0) && (r_found <= n_eff)))
        else $error("tree child outside the active vertices");

    pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_issue |-> (r_sp > 7'd1))
        else $error("pop below the root frame");

endmodule

`default_nettype wire

### hw/rtl/apc_ctrl.sv
// ----------------------------------------------------------------------------
// apc_ctrl: sequencer of the articulation point counter
// Steps through edge loads, the depth-first walk, result hand-off and the
// clearing sweep, issuing one group of datapath commands per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_ctrl
    import apc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire logic     i_cmd,
    output logic          o_stall,
    output logic          o_valid,
    input  wire logic     i_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_cmd == CMD_FINISH) begin
                        o_cmd.find_start = 1'b1;
                        n_state          = S_OUTER;
                    end else if (i_stat.edge_ok) begin
                        o_cmd.edge_load = 1'b1;
                        n_state         = S_EDGE_A;
                    end
                end
            end
            S_EDGE_A: begin
                o_cmd.edge_wa = 1'b1;
                n_state       = S_EDGE_B;
            end
            S_EDGE_B: begin
                o_cmd.edge_wb = 1'b1;
                n_state       = S_IDLE;
            end
            S_OUTER: begin
                if (i_stat.outer_over) begin
                    n_state = S_EMIT;
                end else if (i_stat.outer_visited) begin
                    o_cmd.outer_next = 1'b1;
                end else begin
                    o_cmd.root_start = 1'b1;
                    n_state          = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.row_load = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.u_over) begin
                    if (i_stat.sp_one) begin
                        o_cmd.pop_root_end = 1'b1;
                        n_state            = S_OUTER;
                    end else begin
                        o_cmd.pop_issue = 1'b1;
                        n_state         = S_POP;
                    end
                end else if (i_stat.row_hit) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = S_CHECK;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_CHECK: begin
                if (!i_stat.u_visited) begin
                    o_cmd.tree_push = 1'b1;
                    n_state         = S_LOAD;
                end else begin
                    o_cmd.back_edge = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_POP: begin
                o_cmd.pop_apply = 1'b1;
                n_state         = S_LOAD;
            end
            S_EMIT: begin
                if (!i_stall) begin
                    n_state = S_CLEAR;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    emit_then_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> (r_state == S_CLEAR))
        else $error("result taken without clearing the graph");

    edge_two_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.edge_load |=> o_cmd.edge_wa ##1 o_cmd.edge_wb)
        else $error("edge load did not write both rows");

    hit_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_hit |=> (o_cmd.tree_push || o_cmd.back_edge))
        else $error("neighbor found but not classified");

endmodule

`default_nettype wire
